// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the 3x3 box blur.
package bb3_pkg;

  // Default frame limits and dimensions after reset
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;

  // Configuration port
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Input beat kinds carried on tuser
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_DRAIN = 1'b1;

  // Datapath widths
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned PIXEL_W     = NUM_CHAN * CHAN_W;
  localparam int unsigned SUM_W       = 12;   // nine times 255 fits
  localparam int unsigned CNT_W       = 4;    // up to nine neighbours
  localparam int unsigned NUM_W       = SUM_W + 1;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  // Pixel with red in the lowest bits, as on the stream buses
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // One line store entry: the two rows above the current one
  typedef struct packed {
    pixel_t newer;
    pixel_t older;
  } line_pair_t;

  // Item held in the window stage
  typedef struct packed {
    pixel_t pix;
    logic   emit;
    logic   last;
    logic   row_lo_ok;
    logic   row_hi_ok;
    logic   col_lo_ok;
    logic   col_hi_ok;
  } item_t;

  // Masked neighbourhood sums handed to the divider
  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] count;
    logic             last;
  } sum_t;

  // Saturate a frame dimension into 1..hi
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    int unsigned r;
    if (v < 1) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Reciprocal of 2*count scaled by 2**RECIP_SHIFT, rounded up; exact for sums up to 9*255
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/bb3_line_store.sv =====
`timescale 1ns / 1ps
// Line store: one entry per column holding the two previous rows, write-first read.
module bb3_line_store #(
  parameter int unsigned DEPTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bb3_pkg::line_pair_t wr_data,
  output bb3_pkg::line_pair_t rd_data
);

  bb3_pkg::line_pair_t mem [DEPTH];

  // Write, and read with the fresh data forwarded on an address match
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

// ===== design/bb3_window.sv =====
`timescale 1ns / 1ps
// 3x3 window: shift in one column per beat and register the masked channel sums.
module bb3_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            capture,
  input  bb3_pkg::item_t  item,
  input  bb3_pkg::pixel_t older,
  input  bb3_pkg::pixel_t newer,
  output bb3_pkg::sum_t   sums
);

  localparam int unsigned CW = bb3_pkg::CHAN_W;
  localparam int unsigned SW = bb3_pkg::SUM_W;
  localparam int unsigned NW = bb3_pkg::CNT_W;

  bb3_pkg::pixel_t win      [3][3];
  bb3_pkg::pixel_t win_next [3][3];
  bb3_pkg::pixel_t col      [3];
  logic [SW-1:0]   row_sum  [3][3];   // [row][channel]
  logic [SW-1:0]   tot      [3];
  logic [NW-1:0]   n_rows;
  logic [NW-1:0]   n_cols;

  // Build the shifted window with the new column on the right
  always_comb begin
    col[0] = older;
    col[1] = newer;
    col[2] = item.pix;
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
      win_next[r][2] = col[r];
    end
  end

  // Sum each row over in-frame columns, then the in-frame rows
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        row_sum[r][k] = (item.col_lo_ok ? SW'(win_next[r][0][CW*k +: CW]) : '0)
                      + SW'(win_next[r][1][CW*k +: CW])
                      + (item.col_hi_ok ? SW'(win_next[r][2][CW*k +: CW]) : '0);
      end
    end
    for (int k = 0; k < 3; k++) begin
      tot[k] = (item.row_lo_ok ? row_sum[0][k] : '0) + row_sum[1][k]
             + (item.row_hi_ok ? row_sum[2][k] : '0);
    end
    n_rows = NW'(1) + NW'(item.row_lo_ok) + NW'(item.row_hi_ok);
    n_cols = NW'(1) + NW'(item.col_lo_ok) + NW'(item.col_hi_ok);
  end

  // Advance the window on every beat leaving this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift) begin
      win <= win_next;
    end
  end

  // Hold the sums of a beat that produces a result
  always_ff @(posedge clk) begin
    if (capture) begin
      sums.red_sum   <= tot[0];
      sums.green_sum <= tot[1];
      sums.blue_sum  <= tot[2];
      sums.count     <= NW'(n_rows * n_cols);
      sums.last      <= item.last;
    end
  end

endmodule

// ===== design/bb3_divide.sv =====
`timescale 1ns / 1ps
// Rounded mean: (2*sum + count) / (2*count) by reciprocal multiply, into the output register.
module bb3_divide (
  input  logic            clk,
  input  logic            load,
  input  bb3_pkg::sum_t   sums,
  output bb3_pkg::pixel_t result,
  output logic            last
);

  localparam int unsigned NW = bb3_pkg::NUM_W;
  localparam int unsigned PW = bb3_pkg::PROD_W;
  localparam int unsigned CW = bb3_pkg::CHAN_W;

  logic [bb3_pkg::SUM_W-1:0]   chan_sum [3];
  logic [NW-1:0]               num      [3];
  logic [PW-1:0]               prod     [3];
  logic [CW-1:0]               quo      [3];
  logic [bb3_pkg::RECIP_W-1:0] recip_val;

  // One multiplier per channel, exact for every reachable sum
  always_comb begin
    chan_sum[0] = sums.red_sum;
    chan_sum[1] = sums.green_sum;
    chan_sum[2] = sums.blue_sum;
    recip_val   = bb3_pkg::recip(sums.count);
    for (int k = 0; k < 3; k++) begin
      num[k]  = {chan_sum[k], 1'b0} + NW'(sums.count);
      prod[k] = PW'(num[k]) * PW'(recip_val);
      quo[k]  = prod[k][bb3_pkg::RECIP_SHIFT +: CW];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      result.red   <= quo[0];
      result.green <= quo[1];
      result.blue  <= quo[2];
      last         <= sums.last;
    end
  end

endmodule

// ===== design/box_blur_3x3_border_aware_unit.sv =====
`timescale 1ns / 1ps
// Top level of the border-aware 3x3 box blur over an RGB raster stream.
//
// Usage:
//   Slave channel: one beat per pixel in raster order; s_tdata holds red, green, blue
//   and s_tuser marks a drain beat. The result for a pixel comes out one row plus one
//   pixel later, so after the frame the source sends image_width+1 drain beats.
//   Master channel: one beat per output pixel, m_tlast on the last pixel of the frame.
//   Config channel: cfg_index 0 is the width, 1 the height; always ready. Any write
//   restarts the frame counters. Write only while the block is idle.
// Timing:
//   Throughput is one beat per cycle until backpressure fills the pipeline. The beat
//   that completes a neighbourhood is registered with its line store read, then its
//   window sums, then its reciprocal multiply in the output register behind m_tvalid.
//   The line store is read at the column of the incoming beat and written at the
//   column of the held beat; a write-first bypass covers a one-pixel-wide frame.
// Reset: rst clears the counters, window and pipeline valids and reloads 640 x 480. The
//   line store keeps its contents; entries read before being written are masked.
// Backpressure: while m_tready is low the output beat holds; the pipeline closes up its
//   bubbles and s_tready drops only once every stage holds a result.
module box_blur_3x3_border_aware_unit #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bb3_pkg::PIXEL_W-1:0]     s_tdata,   // red_in, green_in, blue_in
  input  logic                            s_tuser,   // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bb3_pkg::PIXEL_W-1:0]     m_tdata,   // red_out, green_out, blue_out
  output logic                            m_tlast,   // frame_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  // Configuration and frame position
  logic [WW-1:0] img_width;
  logic [HW-1:0] img_height;
  logic [WW-1:0] img_width_next;
  logic [HW-1:0] img_height_next;
  logic [AW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [AW-1:0] in_col_next;
  logic [RW-1:0] in_row_next;

  // Pipeline
  logic                b_valid;
  bb3_pkg::item_t      b_item;
  logic [AW-1:0]       b_addr;
  logic                c_valid;
  logic                o_valid;
  logic                b_valid_next;
  logic                c_valid_next;
  logic                o_valid_next;
  logic                o_load;
  logic                c_load;
  logic                b_move;
  logic                accept;
  logic                c_capture;
  logic                o_capture;
  logic                cfg_write;

  // Accept-side decode
  logic [AW-1:0]       col_cur;
  logic [WW:0]         col_inc;
  logic [WW:0]         width_x;
  logic                col_wrap;
  logic                row_live;
  logic [RW-1:0]       out_row;
  logic [WW-1:0]       out_col;
  bb3_pkg::item_t      item_next;

  bb3_pkg::line_pair_t rd_pair;
  bb3_pkg::line_pair_t wr_pair;
  bb3_pkg::sum_t       sums;
  bb3_pkg::pixel_t     result;
  logic                result_last;

  // Handshakes: each stage loads when empty or moving on
  always_comb begin
    o_load    = !o_valid || m_tready;
    c_load    = !c_valid || o_load;
    b_move    = b_valid && (!b_item.emit || c_load);
    s_tready  = !b_valid || b_move;
    accept    = s_tvalid && s_tready;
    c_capture = b_move && b_item.emit;
    o_capture = c_valid && o_load;
    cfg_ready = 1'b1;
    cfg_write = cfg_valid && cfg_ready;

    b_valid_next = accept || (b_valid && !b_move);
    c_valid_next = c_capture || (c_valid && !o_load);
    o_valid_next = o_capture || (o_valid && !m_tready);
  end

  // Decode the frame position of the incoming beat and the mask of its result
  always_comb begin
    col_cur  = (WW'(in_col) >= img_width) ? '0 : in_col;
    width_x  = {1'b0, img_width};
    col_inc  = (WW + 1)'(col_cur) + (WW + 1)'(1);
    col_wrap = col_inc >= width_x;
    row_live = RW'(img_height) > in_row;

    // Result position trails by one row and one pixel
    if (col_cur != '0) begin
      out_row = in_row - RW'(1);
      out_col = WW'(col_cur) - WW'(1);
    end else begin
      out_row = in_row - RW'(2);
      out_col = img_width - WW'(1);
    end

    item_next.pix       = (row_live && (s_tuser == bb3_pkg::ACTION_PIXEL)) ? s_tdata : '0;
    item_next.emit      = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (col_cur != '0));
    item_next.last      = (col_cur == '0) && (in_row == (RW'(img_height) + RW'(1)));
    item_next.row_lo_ok = out_row != '0;
    item_next.row_hi_ok = ((RW + 1)'(out_row) + (RW + 1)'(1)) < (RW + 1)'(img_height);
    item_next.col_lo_ok = out_col != '0;
    item_next.col_hi_ok = ((WW + 1)'(out_col) + (WW + 1)'(1)) < width_x;
  end

  // Advance the input position; restart on end of frame or a config write
  always_comb begin
    in_col_next = in_col;
    in_row_next = in_row;
    if (cfg_write) begin
      in_col_next = '0;
      in_row_next = '0;
    end else if (accept) begin
      if (item_next.last) begin
        in_col_next = '0;
        in_row_next = '0;
      end else if (col_wrap) begin
        in_col_next = '0;
        in_row_next = in_row + RW'(1);
      end else begin
        in_col_next = col_inc[AW-1:0];
      end
    end
  end

  // Decode config writes, saturating the dimensions
  always_comb begin
    img_width_next  = img_width;
    img_height_next = img_height;
    if (cfg_write) begin
      unique case (cfg_index)
        bb3_pkg::CFG_IMAGE_WIDTH: begin
          img_width_next = WW'(bb3_pkg::clamp_dim(
              32'(cfg_data[bb3_pkg::CFG_WIDTH_W-1:0]), MAX_WIDTH));
        end
        bb3_pkg::CFG_IMAGE_HEIGHT: begin
          img_height_next = HW'(bb3_pkg::clamp_dim(
              32'(cfg_data[bb3_pkg::CFG_HEIGHT_W-1:0]), MAX_HEIGHT));
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= WW'(bb3_pkg::clamp_dim(bb3_pkg::RESET_WIDTH, MAX_WIDTH));
      img_height <= HW'(bb3_pkg::clamp_dim(bb3_pkg::RESET_HEIGHT, MAX_HEIGHT));
      in_col     <= '0;
      in_row     <= '0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      img_width  <= img_width_next;
      img_height <= img_height_next;
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      b_valid    <= b_valid_next;
      c_valid    <= c_valid_next;
      o_valid    <= o_valid_next;
    end
  end

  // Hold the accepted beat for the window stage
  always_ff @(posedge clk) begin
    if (accept) begin
      b_item <= item_next;
      b_addr <= col_cur;
    end
  end

  // Rotate the rows: the newer row drops to older, the current pixel becomes newer
  always_comb begin
    wr_pair.older = rd_pair.newer;
    wr_pair.newer = b_item.pix;
  end

  bb3_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .wr_en   (b_move),
    .wr_addr (b_addr),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  bb3_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_move),
    .capture (c_capture),
    .item    (b_item),
    .older   (rd_pair.older),
    .newer   (rd_pair.newer),
    .sums    (sums)
  );

  bb3_divide u_divide (
    .clk    (clk),
    .load   (o_capture),
    .sums   (sums),
    .result (result),
    .last   (result_last)
  );

  assign m_tvalid = o_valid;
  assign m_tdata  = result;
  assign m_tlast  = result_last;

endmodule

// ===== design/bb3_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the box blur, bound to the top level.
module bb3_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [bb3_pkg::PIXEL_W-1:0] m_tdata,
  input logic                        m_tlast
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output beat changed or dropped");

  // Reset empties the pipeline
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // Input is refused only while a finished result is stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> (m_tvalid && !m_tready))
    else $error("input refused while the output is free");

endmodule

bind box_blur_3x3_border_aware_unit bb3_checker u_bb3_checker (.*);
